// ----- src/baroalt_pkg.sv -----
// Shared types, widths, register codes and the power lookup table for the
// barometric altitude block. No dependencies.
package baroalt_pkg;

   // field widths
   localparam int PRESS_W    = 21;
   localparam int TEMP_W     = 15;
   localparam int ALT_W      = 24;
   localparam int INTERVAL_W = 8;
   localparam int SKIP_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   // ratio and power datapath
   localparam int RATIO_W   = 18;  // Q2.16 pressure ratio
   localparam int FRAC_W    = 10;  // interpolation fraction
   localparam int IDX_W     = RATIO_W - FRAC_W;
   localparam int POW_W     = 17;  // table entries, Q.16
   localparam int ROM_DEPTH = 257;
   localparam int ROM_IDX_W = 9;
   localparam int DELTA_W   = 18;  // signed 1 - r^e, Q.16
   localparam int PROD_W    = ALT_W + DELTA_W;
   localparam int STEP_W    = 5;   // divider step counter

   localparam int SAMPLES_LOG2_DEF = 3;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [ALT_W-1:0]   ALT_SCALE_CM  = ALT_W'(4433000);
   localparam logic [PRESS_W-1:0] TINY_PRESSURE = PRESS_W'(16);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP      = 2'd2;

   // reset values of the registers
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = INTERVAL_W'(10);
   localparam logic [PRESS_W-1:0]    MIN_PRESS_RST = PRESS_W'(480000);
   localparam logic [SKIP_W-1:0]     SKIP_RST      = SKIP_W'(8);

   // what the back end has to do with a request
   typedef enum logic [1:0] {
      JOB_HOLD    = 2'd0,  // present, no sample due: record kept
      JOB_INVALID = 2'd1,  // absent or failed read: record marked invalid
      JOB_SAMPLE  = 2'd2   // good read: new record
   } job_kind_type;

   typedef struct packed {
      job_kind_type             kind;
      logic                     healthy;
      logic                     locked;
      logic                     alt_zero;
      logic [PRESS_W-1:0]       pressure;
      logic signed [TEMP_W-1:0] temperature;
      logic [PRESS_W-1:0]       ground;
   } job_type;

   typedef logic [POW_W-1:0] pow_rom_type [ROM_DEPTH];

   localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
   localparam logic [63:0] LN2_Q32  = 64'd2977044472;

   // log2(v) in Q30, v >= 1
   function automatic logic [63:0] log2_q30(input logic [31:0] v);
      logic [63:0] m;
      logic [63:0] res;
      int          k;
      k = 0;
      for (int j = 1; j < 32; j++) begin
         if ((v >> j) != 32'd0) k = j;
      end
      m   = ({32'd0, v} << 30) >> k;
      res = 64'(k) << 30;
      for (int b = 29; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= (Q30_ONE << 1)) begin
            m      = m >> 1;
            res[b] = 1'b1;
         end
      end
      return res;
   endfunction

   // 2^f in Q30 for 0 <= f < 1, Taylor series of e^(f ln2)
   function automatic logic [63:0] exp2_frac_q30(input logic [63:0] f);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      x    = (f * LN2_Q32) >> 32;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int k = 1; k <= 14; k++) begin
         term = ((term * x) >> 30) / 64'(k);
         sum  = sum + term;
      end
      return sum;
   endfunction

   // entry i = round(65536 * (i/64)^(200/1051))
   function automatic pow_rom_type build_pow_rom();
      pow_rom_type rom;
      longint      d;
      longint      t;
      logic [63:0] ut;
      logic [63:0] n;
      logic [63:0] v;
      rom[0] = '0;
      for (int i = 1; i < ROM_DEPTH; i++) begin
         d      = longint'(log2_q30(32'(i))) - longint'(64'd6 << 30);
         t      = longint'(64'd16 << 30) + (d * 200) / 1051;
         ut     = 64'(t);
         n      = ut >> 30;
         v      = exp2_frac_q30(ut & (Q30_ONE - 64'd1));
         rom[i] = POW_W'(((v << n) + (Q30_ONE >> 1)) >> 30);
      end
      return rom;
   endfunction

   localparam pow_rom_type POW_ROM = build_pow_rom();

endpackage

// ----- src/baroalt_if.sv -----
// Channel interfaces: sensor request, altitude record response, register write.
// Depends on baroalt_pkg.
interface baroalt_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  present;
   logic                                  read_ok;
   logic [baroalt_pkg::PRESS_W-1:0]       pressure;
   logic signed [baroalt_pkg::TEMP_W-1:0] temperature;

   modport source (output valid, present, read_ok, pressure, temperature, input ready);
   modport sink   (input valid, present, read_ok, pressure, temperature, output ready);
endinterface

interface baroalt_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  sample_valid;
   logic                                  healthy;
   logic                                  baseline_locked;
   logic [baroalt_pkg::PRESS_W-1:0]       latest_pressure;
   logic signed [baroalt_pkg::TEMP_W-1:0] latest_temperature;
   logic signed [baroalt_pkg::ALT_W-1:0]  altitude_cm;

   modport source (output valid, sample_valid, healthy, baseline_locked, latest_pressure,
                   latest_temperature, altitude_cm, input ready);
   modport sink   (input valid, sample_valid, healthy, baseline_locked, latest_pressure,
                   latest_temperature, altitude_cm, output ready);
endinterface

interface baroalt_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [baroalt_pkg::CSR_IDX_W-1:0]    index;
   logic [baroalt_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/baroalt_queue.sv -----
// Small job queue between front and back end.
// Depends on baroalt_pkg.
module baroalt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  baroalt_pkg::job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output baroalt_pkg::job_type pop_job
);
   import baroalt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ----- src/baroalt_front.sv -----
// Front end: register writes, sample decimation, health flag and ground
// baseline averaging; classifies each request into a job. Depends on baroalt_pkg.
module baroalt_front #(
   parameter int SAMPLES_LOG2 = baroalt_pkg::SAMPLES_LOG2_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   baroalt_req_if.sink          req_ch,
   baroalt_csr_if.sink          csr_ch,
   input  logic                 queue_full,
   output logic                 push,
   output baroalt_pkg::job_type push_job
);
   import baroalt_pkg::*;

   localparam int SUM_W = PRESS_W + SAMPLES_LOG2;
   localparam int CNT_W = SAMPLES_LOG2 + 1;
   localparam logic [CNT_W-1:0] AVG_TARGET = CNT_W'(1) << SAMPLES_LOG2;

   logic [INTERVAL_W-1:0] interval_ff;
   logic [PRESS_W-1:0]    min_press_ff;
   logic [SKIP_W-1:0]     skip_ff;

   logic [INTERVAL_W-1:0] tick_ff, tick_in;
   logic [SKIP_W-1:0]     skipped_ff, skipped_in;
   logic [CNT_W-1:0]      averaged_ff, averaged_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [PRESS_W-1:0]    ground_ff, ground_in;
   logic                  locked_ff, locked_in;
   logic                  healthy_ff, healthy_in;

   logic [INTERVAL_W-1:0] tick_inc;
   logic [SUM_W-1:0]      sum_add;
   logic [CNT_W-1:0]      averaged_inc;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RST;
         min_press_ff <= MIN_PRESS_RST;
         skip_ff      <= SKIP_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_INTERVAL:  interval_ff  <= csr_ch.data[INTERVAL_W-1:0];
            CSR_MIN_PRESS: min_press_ff <= csr_ch.data[PRESS_W-1:0];
            CSR_SKIP:      skip_ff      <= csr_ch.data[SKIP_W-1:0];
            default: ;
         endcase
      end
   end

   // classify the request and advance the baseline
   always_comb begin
      tick_inc     = tick_ff + INTERVAL_W'(1);
      sum_add      = sum_ff + SUM_W'(req_ch.pressure);
      averaged_inc = averaged_ff + CNT_W'(1);

      tick_in     = tick_ff;
      skipped_in  = skipped_ff;
      averaged_in = averaged_ff;
      sum_in      = sum_ff;
      ground_in   = ground_ff;
      locked_in   = locked_ff;
      healthy_in  = healthy_ff;
      push_job.kind = JOB_INVALID;

      if (req_ch.present) begin
         if (tick_inc >= interval_ff) begin
            tick_in = '0;
            if (!req_ch.read_ok) begin
               healthy_in = 1'b0;
            end else begin
               push_job.kind = JOB_SAMPLE;
               healthy_in    = 1'b1;
               if (!locked_ff && (req_ch.pressure > min_press_ff)) begin
                  if (skipped_ff < skip_ff) begin
                     skipped_in = skipped_ff + SKIP_W'(1);
                  end else begin
                     sum_in      = sum_add;
                     averaged_in = averaged_inc;
                     if (averaged_inc >= AVG_TARGET) begin
                        ground_in = PRESS_W'(sum_add >> SAMPLES_LOG2);
                        locked_in = 1'b1;
                     end
                  end
               end
            end
         end else begin
            tick_in       = tick_inc;
            push_job.kind = JOB_HOLD;
         end
      end

      push_job.healthy     = healthy_in;
      push_job.locked      = locked_in;
      push_job.alt_zero    = !locked_in || (ground_in <= TINY_PRESSURE) ||
                             (req_ch.pressure <= TINY_PRESSURE);
      push_job.pressure    = req_ch.pressure;
      push_job.temperature = req_ch.temperature;
      push_job.ground      = ground_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         skipped_ff  <= '0;
         averaged_ff <= '0;
         sum_ff      <= '0;
         ground_ff   <= '0;
         locked_ff   <= 1'b0;
         healthy_ff  <= 1'b0;
      end else if (push) begin
         tick_ff     <= tick_in;
         skipped_ff  <= skipped_in;
         averaged_ff <= averaged_in;
         sum_ff      <= sum_in;
         ground_ff   <= ground_in;
         locked_ff   <= locked_in;
         healthy_ff  <= healthy_in;
      end
   end

endmodule

// ----- src/baroalt_back.sv -----
// Back end: pressure ratio divider, power table interpolation, altitude
// scaling and the latest-sample record with its response register.
// Depends on baroalt_pkg.
module baroalt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  baroalt_pkg::job_type queue_job,
   output logic                 pop,
   baroalt_rsp_if.source        rsp_ch
);
   import baroalt_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_INTERP = 6'b001000,
      ST_SCALE  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   job_type                    job_ff;
   logic [PRESS_W-1:0]         rem_ff, rem_in;
   logic [RATIO_W-1:0]         dshift_ff, dshift_in;
   logic [RATIO_W-1:0]         quot_ff, quot_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [POW_W-1:0]           t0_ff, t1_ff;
   logic [FRAC_W-1:0]          frac_ff;
   logic [POW_W-1:0]           pw_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic                       rec_valid_ff;
   logic [PRESS_W-1:0]         rec_pressure_ff;
   logic signed [TEMP_W-1:0]   rec_temperature_ff;
   logic signed [ALT_W-1:0]    rec_altitude_ff;
   logic                       out_healthy_ff;
   logic                       out_locked_ff;
   logic                       rsp_valid_ff;

   logic                       slot_free;
   logic                       finish;
   logic [PRESS_W:0]           trial;
   logic                       take;
   logic [IDX_W-1:0]           idx;
   logic [POW_W+FRAC_W-1:0]    slope;
   logic signed [DELTA_W-1:0]  delta;
   logic signed [PROD_W-1:0]   rounded;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign finish    = (state_ff == ST_FINISH) && slot_free;
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;

   // one restoring divide step
   assign trial = {rem_ff, dshift_ff[RATIO_W-1]};
   assign take  = (trial >= {1'b0, job_ff.ground});

   assign idx     = quot_ff[RATIO_W-1:FRAC_W];
   assign slope   = (t1_ff - t0_ff) * frac_ff;
   assign delta   = DELTA_W'(1 << 16) - DELTA_W'(pw_ff);
   assign rounded = (prod_ff + PROD_W'(32768)) >>> 16;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      dshift_in = dshift_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;
      prod_in   = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               prod_in = '0;
               if ((queue_job.kind != JOB_SAMPLE) || queue_job.alt_zero) begin
                  state_in = ST_FINISH;
               end else if ((queue_job.pressure >> 2) >= queue_job.ground) begin
                  // ratio of four or more saturates
                  quot_in  = '1;
                  state_in = ST_LOOKUP;
               end else begin
                  rem_in    = queue_job.pressure >> 2;
                  dshift_in = {queue_job.pressure[1:0], 16'd0};
                  quot_in   = '0;
                  step_in   = STEP_W'(RATIO_W - 1);
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in    = take ? PRESS_W'(trial - {1'b0, job_ff.ground}) : trial[PRESS_W-1:0];
            quot_in   = {quot_ff[RATIO_W-2:0], take};
            dshift_in = dshift_ff << 1;
            step_in   = step_ff - STEP_W'(1);
            if (step_ff == '0) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_INTERP;
         ST_INTERP: state_in = ST_SCALE;
         ST_SCALE: begin
            prod_in  = $signed({1'b0, ALT_SCALE_CM}) * delta;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) job_ff <= queue_job;
      rem_ff    <= rem_in;
      dshift_ff <= dshift_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
      prod_ff   <= prod_in;
      if (state_ff == ST_LOOKUP) begin
         t0_ff   <= POW_ROM[{1'b0, idx}];
         t1_ff   <= POW_ROM[ROM_IDX_W'({1'b0, idx}) + ROM_IDX_W'(1)];
         frac_ff <= quot_ff[FRAC_W-1:0];
      end
      if (state_ff == ST_INTERP) begin
         pw_ff <= t0_ff + POW_W'(slope >> FRAC_W);
      end
   end

   // latest-sample record and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff       <= 1'b0;
         rec_pressure_ff    <= '0;
         rec_temperature_ff <= '0;
         rec_altitude_ff    <= '0;
         out_healthy_ff     <= 1'b0;
         out_locked_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (finish) begin
            rsp_valid_ff   <= 1'b1;
            out_healthy_ff <= job_ff.healthy;
            out_locked_ff  <= job_ff.locked;
            case (job_ff.kind)
               JOB_SAMPLE: begin
                  rec_valid_ff       <= 1'b1;
                  rec_pressure_ff    <= job_ff.pressure;
                  rec_temperature_ff <= job_ff.temperature;
                  rec_altitude_ff    <= rounded[ALT_W-1:0];
               end
               JOB_INVALID: rec_valid_ff <= 1'b0;
               default: ;
            endcase
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.sample_valid       = rec_valid_ff;
   assign rsp_ch.healthy            = out_healthy_ff;
   assign rsp_ch.baseline_locked    = out_locked_ff;
   assign rsp_ch.latest_pressure    = rec_pressure_ff;
   assign rsp_ch.latest_temperature = rec_temperature_ff;
   assign rsp_ch.altitude_cm        = rec_altitude_ff;

endmodule

// ----- src/baro_altitude_with_baseline.sv -----
// Barometric altitude with ground baseline: every request (one control-loop
// tick) returns one response, the latest-sample record. The front end takes a
// request whenever its two-entry job queue has room, so up to two ticks can
// be queued while the back end works. A tick that takes a good sample with
// the baseline locked runs through job fetch, the bit-serial pressure ratio
// divider, table lookup, interpolation, scaling and the response register;
// a saturated ratio skips the divider, and any other tick goes from job fetch
// to the response register. The divider sets the sustained rate while
// responses are taken. Registers may be written at any time the block is
// idle; reset restores interval 10, floor 480000 and skip count 8.
// Depends on baroalt_pkg, the channel interfaces, front, queue and back.
module baro_altitude_with_baseline #(
   parameter int SAMPLES_LOG2 = baroalt_pkg::SAMPLES_LOG2_DEF
) (
   input  logic          clock,
   input  logic          reset,
   baroalt_req_if.sink   req_ch,
   baroalt_rsp_if.source rsp_ch,
   baroalt_csr_if.sink   csr_ch
);
   import baroalt_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;
   job_type push_job;
   job_type pop_job;

   baroalt_front #(
      .SAMPLES_LOG2 (SAMPLES_LOG2)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   baroalt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_job  (pop_job)
   );

   baroalt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_job   (pop_job),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule
